// File: rtl/qpfe_pkg.sv
package qpfe_pkg;

    typedef enum logic [2:0] {
        MODE_INDEXED   = 3'd0,
        MODE_NAME_REF  = 3'd1,
        MODE_VALUE_LEN = 3'd2,
        MODE_NAME_LEN  = 3'd3,
        MODE_RAW       = 3'd4,
        MODE_FINISH    = 3'd5
    } t_mode;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_FINISHED = 2'd2;

    localparam logic CFG_MAX_LEN  = 1'b0;
    localparam logic CFG_HUFF_MIN = 1'b1;

    localparam logic [31:0] MAX_LEN_RESET  = 32'd65536;
    localparam logic [15:0] HUFF_MIN_RESET = 16'd8;

    localparam logic [7:0] MASK_INDEXED  = 8'hc0;
    localparam logic [7:0] MASK_NAME_REF = 8'h50;
    localparam logic [7:0] MASK_VALUE    = 8'h00;
    localparam logic [7:0] HBIT_VALUE    = 8'h80;
    localparam logic [7:0] MASK_NAME     = 8'h20;
    localparam logic [7:0] HBIT_NAME     = 8'h08;

    // prefix maxima for 6, 4, 7 and 3 bit prefixes
    localparam logic [7:0] PMAX_INDEXED  = 8'h3f;
    localparam logic [7:0] PMAX_NAME_REF = 8'h0f;
    localparam logic [7:0] PMAX_VALUE    = 8'h7f;
    localparam logic [7:0] PMAX_NAME     = 8'h07;

    localparam logic [7:0] PREFIX_BYTE = 8'h00;
    localparam logic       CONT_FLAG   = 1'b1;

    typedef struct packed {
        logic        prefix;
        logic        has_first;
        logic        more;
        logic        huff;
        logic [1:0]  status;
        logic [7:0]  first;
        logic [63:0] rem;
    } t_cmd;

    typedef enum logic [2:0] {
        SER_IDLE,
        SER_PRE0,
        SER_PRE1,
        SER_FIRST,
        SER_CONT,
        SER_EMPTY
    } t_ser_state;

endpackage

// File: rtl/qpfe_classify.sv
module qpfe_classify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_mode,
    input  logic [63:0]        i_number,
    input  logic [63:0]        i_huffman_length,
    input  logic [7:0]         i_octet,
    input  logic [31:0]        i_max_len,
    input  logic [15:0]        i_huff_min,
    output qpfe_pkg::t_cmd     o_cmd
);

    logic        r_prefix_sent;
    logic        r_finished;

    logic        too_long;
    logic        want_huff;
    logic [7:0]  pmax;
    logic [7:0]  mask;
    logic        active;
    logic        is_int;
    logic        is_raw;
    logic        huff;
    logic        finish;
    logic [1:0]  status;
    logic        ok;
    logic        num_small;
    logic        hl_small;
    logic        fits;
    logic [63:0] num_rem;
    logic [63:0] hl_rem;
    logic [7:0]  low_byte;

    assign too_long  = (i_number[63:32] != '0) || (i_number[31:0] > i_max_len);
    assign want_huff = (i_number != '0) && (i_number >= {48'd0, i_huff_min})
                       && (i_huffman_length < i_number);

    always_comb begin
        pmax   = qpfe_pkg::PMAX_INDEXED;
        mask   = qpfe_pkg::MASK_INDEXED;
        active = 1'b1;
        is_int = 1'b0;
        is_raw = 1'b0;
        huff   = 1'b0;
        finish = 1'b0;
        status = qpfe_pkg::STAT_OK;
        case (i_mode)
            qpfe_pkg::MODE_INDEXED: begin
                is_int = 1'b1;
            end
            qpfe_pkg::MODE_NAME_REF: begin
                pmax   = qpfe_pkg::PMAX_NAME_REF;
                mask   = qpfe_pkg::MASK_NAME_REF;
                is_int = 1'b1;
            end
            qpfe_pkg::MODE_VALUE_LEN: begin
                pmax = qpfe_pkg::PMAX_VALUE;
                mask = want_huff ? (qpfe_pkg::MASK_VALUE | qpfe_pkg::HBIT_VALUE)
                                 : qpfe_pkg::MASK_VALUE;
                if (too_long) begin
                    status = qpfe_pkg::STAT_INVALID;
                end else begin
                    is_int = 1'b1;
                    huff   = want_huff;
                end
            end
            qpfe_pkg::MODE_NAME_LEN: begin
                pmax = qpfe_pkg::PMAX_NAME;
                mask = want_huff ? (qpfe_pkg::MASK_NAME | qpfe_pkg::HBIT_NAME)
                                 : qpfe_pkg::MASK_NAME;
                if (too_long || (i_number == '0)) begin
                    status = qpfe_pkg::STAT_INVALID;
                end else begin
                    is_int = 1'b1;
                    huff   = want_huff;
                end
            end
            qpfe_pkg::MODE_RAW: begin
                is_raw = 1'b1;
            end
            qpfe_pkg::MODE_FINISH: begin
                finish = 1'b1;
            end
            default: begin
                active = 1'b0;
            end
        endcase

        if (r_finished) begin
            active = 1'b0;
            is_int = 1'b0;
            is_raw = 1'b0;
            huff   = 1'b0;
            finish = 1'b0;
            status = qpfe_pkg::STAT_FINISHED;
        end

        num_small = (i_number[63:8] == '0) && (i_number[7:0] < pmax);
        hl_small  = (i_huffman_length[63:8] == '0) && (i_huffman_length[7:0] < pmax);
        num_rem   = i_number - {56'd0, pmax};
        hl_rem    = i_huffman_length - {56'd0, pmax};
        fits      = huff ? hl_small : num_small;
        low_byte  = huff ? i_huffman_length[7:0] : i_number[7:0];

        ok = active && (status == qpfe_pkg::STAT_OK);

        o_cmd.prefix    = ok && !r_prefix_sent;
        o_cmd.has_first = is_int || is_raw;
        o_cmd.more      = is_int && !fits;
        o_cmd.huff      = huff;
        o_cmd.status    = status;
        o_cmd.first     = is_raw ? i_octet : (fits ? (mask | low_byte) : (mask | pmax));
        o_cmd.rem       = huff ? hl_rem : num_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_sent <= 1'b0;
            r_finished    <= 1'b0;
        end else if (i_accept && ok) begin
            r_prefix_sent <= 1'b1;
            if (finish) begin
                r_finished <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/qpfe_serial.sv
module qpfe_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  qpfe_pkg::t_cmd  i_cmd,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_last,
    output logic [1:0]      o_status,
    output logic            o_huffman_chosen
);

    qpfe_pkg::t_ser_state r_state;
    qpfe_pkg::t_ser_state n_state;

    logic [63:0] r_rem;
    logic [63:0] n_rem;
    logic        r_has_first;
    logic        r_more;
    logic        r_huff;
    logic [1:0]  r_stat;
    logic [7:0]  r_first;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bvalid;
    logic        r_out_last;
    logic [1:0]  r_out_status;
    logic        r_out_huff;

    logic        out_free;
    logic        emit;
    logic [7:0]  e_byte;
    logic        e_bvalid;
    logic        e_last;
    logic [1:0]  e_status;
    logic        e_huff;

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpfe_pkg::SER_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        emit     = 1'b0;
        e_byte   = qpfe_pkg::PREFIX_BYTE;
        e_bvalid = 1'b1;
        e_last   = 1'b0;
        e_status = qpfe_pkg::STAT_OK;
        e_huff   = 1'b0;
        case (r_state)
            qpfe_pkg::SER_IDLE: begin
                if (i_load) begin
                    n_rem = i_cmd.rem;
                    if (i_cmd.prefix) begin
                        n_state = qpfe_pkg::SER_PRE0;
                    end else if (i_cmd.has_first) begin
                        n_state = qpfe_pkg::SER_FIRST;
                    end else begin
                        n_state = qpfe_pkg::SER_EMPTY;
                    end
                end
            end
            qpfe_pkg::SER_PRE0: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = qpfe_pkg::SER_PRE1;
                end
            end
            qpfe_pkg::SER_PRE1: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_has_first) begin
                        n_state = qpfe_pkg::SER_FIRST;
                    end else begin
                        e_last  = 1'b1;
                        n_state = qpfe_pkg::SER_IDLE;
                    end
                end
            end
            qpfe_pkg::SER_FIRST: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_byte = r_first;
                    e_huff = r_huff;
                    if (r_more) begin
                        n_state = qpfe_pkg::SER_CONT;
                    end else begin
                        e_last  = 1'b1;
                        n_state = qpfe_pkg::SER_IDLE;
                    end
                end
            end
            qpfe_pkg::SER_CONT: begin
                // one 7-bit group per beat, low group first
                if (out_free) begin
                    emit   = 1'b1;
                    e_huff = r_huff;
                    if (r_rem[63:7] != '0) begin
                        e_byte = {qpfe_pkg::CONT_FLAG, r_rem[6:0]};
                        n_rem  = {7'd0, r_rem[63:7]};
                    end else begin
                        e_byte  = {1'b0, r_rem[6:0]};
                        e_last  = 1'b1;
                        n_state = qpfe_pkg::SER_IDLE;
                    end
                end
            end
            qpfe_pkg::SER_EMPTY: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_bvalid = 1'b0;
                    e_status = r_stat;
                    e_last   = 1'b1;
                    n_state  = qpfe_pkg::SER_IDLE;
                end
            end
            default: begin
                n_state = qpfe_pkg::SER_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if ((r_state == qpfe_pkg::SER_IDLE) && i_load) begin
            r_has_first <= i_cmd.has_first;
            r_more      <= i_cmd.more;
            r_huff      <= i_cmd.huff;
            r_stat      <= i_cmd.status;
            r_first     <= i_cmd.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= e_byte;
            r_out_bvalid <= e_bvalid;
            r_out_last   <= e_last;
            r_out_status <= e_status;
            r_out_huff   <= e_huff;
        end
    end

    assign o_busy           = (r_state != qpfe_pkg::SER_IDLE);
    assign o_valid          = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_out_bvalid;
    assign o_last           = r_out_last;
    assign o_status         = r_out_status;
    assign o_huffman_chosen = r_out_huff;

endmodule

// File: rtl/qpack_field_line_encoder.sv
// QPACK field-section encoder. Each input beat is one encoding step (indexed
// entry, static name reference, value or name length header, raw octet, or
// finish); its bytes leave one per output beat, with the two zero section
// prefix bytes placed ahead of the first valid step's output. A step
// that produces no byte still yields one beat with byte_valid low and the
// status. An item produces 1 to 13 output beats: the input is taken, the
// decode is registered into a shift register that releases one byte (one
// 7-bit group) a cycle while the output is not stalled, and the input is
// ready again once the last byte is in the output register. Config writes
// apply at once and belong to idle periods.
module qpack_field_line_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_number,
    input  logic [63:0] i_huffman_length,
    input  logic [7:0]  i_octet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic        o_huffman_chosen
);

    logic [31:0]    r_max_len;
    logic [15:0]    r_huff_min;
    logic           busy;
    logic           accept;
    qpfe_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= qpfe_pkg::MAX_LEN_RESET;
            r_huff_min <= qpfe_pkg::HUFF_MIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == qpfe_pkg::CFG_MAX_LEN) begin
                r_max_len <= i_cfg_data;
            end else begin
                r_huff_min <= i_cfg_data[15:0];
            end
        end
    end

    assign o_ready = !busy;
    assign accept  = i_valid && !busy;

    qpfe_classify u_classify (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_mode           (i_mode),
        .i_number         (i_number),
        .i_huffman_length (i_huffman_length),
        .i_octet          (i_octet),
        .i_max_len        (r_max_len),
        .i_huff_min       (r_huff_min),
        .o_cmd            (cmd)
    );

    qpfe_serial u_serial (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_cmd            (cmd),
        .o_busy           (busy),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_last           (o_last),
        .o_status         (o_status),
        .o_huffman_chosen (o_huffman_chosen)
    );

endmodule

// File: rtl/qpfe_checker.sv
module qpfe_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic        o_last,
    input logic [1:0]  o_status,
    input logic        o_huffman_chosen
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last && (o_out_byte == 8'h00))
        else $error("byteless beat not final or not zero");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> (o_status == qpfe_pkg::STAT_OK))
        else $error("byte beat with error status");

    a_huff_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_huffman_chosen |-> o_byte_valid)
        else $error("huffman flag on byteless beat");

    // input is held off while an item is still producing beats
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken before first finished");

endmodule

bind qpack_field_line_encoder qpfe_assertions u_qpfe_assertions (.*);
